>>> design/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package mau_pkg;

   localparam int MOD_BITS_DEF = 30;
   localparam int EXP_BITS_DEF = 63;
   localparam int OPA_W        = 30;
   localparam int RES_W        = 30;
   localparam int CMD_W        = 3;

   localparam logic [31:0] MOD_RESET = 32'd998244353;

   localparam logic [CMD_W-1:0] OP_ADD = 3'd0;
   localparam logic [CMD_W-1:0] OP_SUB = 3'd1;
   localparam logic [CMD_W-1:0] OP_MUL = 3'd2;
   localparam logic [CMD_W-1:0] OP_POW = 3'd3;
   localparam logic [CMD_W-1:0] OP_INV = 3'd4;
   localparam logic [CMD_W-1:0] OP_DIV = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_BIT,
      ST_MUL_ACC,
      ST_SQUARE,
      ST_MUL_RES,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {SRC_OPA, SRC_OPB, SRC_MUL} red_src_type;

   typedef enum logic [1:0] {MUL_AB, MUL_ACC_BASE, MUL_SQR, MUL_ACC_A} mul_sel_type;

   typedef enum logic [2:0] {DST_NONE, DST_A, DST_B, DST_ACC, DST_BASE, DST_RES} dst_type;

   typedef enum logic [2:0] {RES_HOLD, RES_ADD, RES_SUB, RES_ACC, RES_ZERO} res_op_type;

   typedef struct packed {
      logic        load;
      logic        red_start;
      red_src_type red_src;
      mul_sel_type mul_sel;
      dst_type     dst;
      logic        pow_init;
      logic        base_from_b;
      logic        exp_from_mod;
      logic        exp_shift;
      res_op_type  res_op;
   } dp_ctl_type;

   typedef struct packed {
      logic red_busy;
      logic red_done;
      logic exp_zero;
      logic exp_lsb;
      logic mod_zero;
      logic mod_lt2;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> design/mau_req_if.sv
// Request channel of the modular arithmetic unit: opcode and two operands.
// Depends on mau_pkg for the fixed field widths.
`default_nettype none

interface mau_req_if import mau_pkg::*; #(
   parameter int EXP_BITS = EXP_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [OPA_W-1:0]    operand_a;
   logic [EXP_BITS-1:0] operand_b;

   modport source (output valid, cmd, operand_a, operand_b, input ready);
   modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

>>> design/mau_rsp_if.sv
// Response channel of the modular arithmetic unit: one residue per word.
// Depends on mau_pkg for the result width.
`default_nettype none

interface mau_rsp_if import mau_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

>>> design/mau_csr_if.sv
// Configuration write channel of the modular arithmetic unit (modulus only).
// Depends on mau_pkg for the default modulus width.
`default_nettype none

interface mau_csr_if import mau_pkg::*; #(
   parameter int MOD_BITS = MOD_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] modulus;

   modport source (output valid, modulus, input ready);
   modport sink   (input valid, modulus, output ready);
endinterface

`default_nettype wire

>>> design/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: wires the channels to mau_ctrl and
// mau_dpath. Depends on mau_pkg and the mau_req_if, mau_rsp_if, mau_csr_if interfaces.
//
//   Channel   Direction  Word contents
//   req_bus   in         cmd, operand_a, operand_b
//   rsp_bus   out        result
//   csr_bus   in         modulus (always ready)
//
// One word is worked at a time. The remainder unit reduces a RED_W-bit dividend
// one bit at a time, RED_W = max(2*MOD_BITS, EXP_BITS, 30), 63 by default.
// Add and subtract take two reductions, multiply three; power and inverse take
// 2 + n + w reductions, n the exponent's bit length and w its count of one bits,
// and divide takes one reduction more.
// Reset returns the modulus to 998244353; no memory needs clearing.
// req_bus.ready stays low from acceptance until the result word is taken.
`default_nettype none

module modular_arithmetic_unit import mau_pkg::*; #(
   parameter int MOD_BITS = MOD_BITS_DEF,
   parameter int EXP_BITS = EXP_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   mau_req_if.sink  req_bus,
   mau_rsp_if.source rsp_bus,
   mau_csr_if.sink  csr_bus
);

   dp_ctl_type ctl;
   dp_sts_type sts;

   assign csr_bus.ready = 1'b1;

   mau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_cmd   (req_bus.cmd),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   mau_dpath #(
      .MOD_BITS (MOD_BITS),
      .EXP_BITS (EXP_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .csr_we        (csr_bus.valid),
      .csr_modulus   (csr_bus.modulus),
      .req_operand_a (req_bus.operand_a),
      .req_operand_b (req_bus.operand_b),
      .rsp_result    (rsp_bus.result)
   );

endmodule

`default_nettype wire

>>> design/mau_ctrl.sv
// Sequencing state machine of the modular arithmetic unit.
// Depends on mau_pkg; drives mau_dpath through dp_ctl_type and reads dp_sts_type.
`default_nettype none

module mau_ctrl import mau_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dp_ctl_type            ctl,
   input  wire dp_sts_type       sts
);

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_cmd;
               ctl.load = 1'b1;
               if (sts.mod_zero) begin
                  ctl.res_op = RES_ZERO;
                  state_in   = ST_OUT;
               end else begin
                  ctl.red_start = 1'b1;
                  ctl.red_src   = SRC_OPA;
                  state_in      = ST_RED_A;
               end
            end
         end
         ST_RED_A: begin
            ctl.dst = DST_A;
            if (sts.red_done) begin
               ctl.red_start = 1'b1;
               ctl.red_src   = SRC_OPB;
               state_in      = ST_RED_B;
            end
         end
         ST_RED_B: begin
            ctl.dst = DST_B;
            if (sts.red_done) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (op_ff) inside
               OP_ADD: begin
                  ctl.res_op = RES_ADD;
                  state_in   = ST_OUT;
               end
               OP_SUB: begin
                  ctl.res_op = RES_SUB;
                  state_in   = ST_OUT;
               end
               OP_MUL: begin
                  ctl.red_start = 1'b1;
                  ctl.red_src   = SRC_MUL;
                  ctl.mul_sel   = MUL_AB;
                  state_in      = ST_MUL_RES;
               end
               OP_POW: begin
                  ctl.pow_init = 1'b1;
                  state_in     = ST_BIT;
               end
               OP_INV, OP_DIV: begin
                  // Fermat inverse needs a modulus of at least two.
                  if (sts.mod_lt2) begin
                     ctl.res_op = RES_ZERO;
                     state_in   = ST_OUT;
                  end else begin
                     ctl.pow_init     = 1'b1;
                     ctl.exp_from_mod = 1'b1;
                     ctl.base_from_b  = (op_ff == OP_DIV);
                     state_in         = ST_BIT;
                  end
               end
               default: begin
                  ctl.res_op = RES_ZERO;
                  state_in   = ST_OUT;
               end
            endcase
         end
         ST_BIT: begin
            if (sts.exp_zero) begin
               if (op_ff == OP_DIV) begin
                  ctl.red_start = 1'b1;
                  ctl.red_src   = SRC_MUL;
                  ctl.mul_sel   = MUL_ACC_A;
                  state_in      = ST_MUL_RES;
               end else begin
                  ctl.res_op = RES_ACC;
                  state_in   = ST_OUT;
               end
            end else if (sts.exp_lsb) begin
               ctl.red_start = 1'b1;
               ctl.red_src   = SRC_MUL;
               ctl.mul_sel   = MUL_ACC_BASE;
               state_in      = ST_MUL_ACC;
            end else begin
               ctl.red_start = 1'b1;
               ctl.red_src   = SRC_MUL;
               ctl.mul_sel   = MUL_SQR;
               state_in      = ST_SQUARE;
            end
         end
         ST_MUL_ACC: begin
            ctl.dst = DST_ACC;
            if (sts.red_done) begin
               ctl.red_start = 1'b1;
               ctl.red_src   = SRC_MUL;
               ctl.mul_sel   = MUL_SQR;
               state_in      = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            ctl.dst = DST_BASE;
            if (sts.red_done) begin
               ctl.exp_shift = 1'b1;
               state_in      = ST_BIT;
            end
         end
         ST_MUL_RES: begin
            ctl.dst = DST_RES;
            if (sts.red_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // Only one word is in flight: an accepted request closes the request side.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a word was in progress");

   // A new reduction may only start when the reducer is free or finishing.
   a_red_start_free: assert property (@(posedge clock) disable iff (reset)
      ctl.red_start |-> (!sts.red_busy || sts.red_done))
      else $error("reduction started while the reducer was busy");
`endif

endmodule

`default_nettype wire

>>> design/mau_dpath.sv
// Datapath of the modular arithmetic unit: modulus register, operand and power
// registers, one multiplier and a bit-serial remainder unit. Depends on mau_pkg.
`default_nettype none

module mau_dpath import mau_pkg::*; #(
   parameter int MOD_BITS = MOD_BITS_DEF,
   parameter int EXP_BITS = EXP_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_ctl_type          ctl,
   output dp_sts_type               sts,
   input  wire logic                csr_we,
   input  wire logic [MOD_BITS-1:0] csr_modulus,
   input  wire logic [OPA_W-1:0]    req_operand_a,
   input  wire logic [EXP_BITS-1:0] req_operand_b,
   output logic [RES_W-1:0]         rsp_result
);

   localparam int PROD_W = 2 * MOD_BITS;
   localparam int RED_W0 = (PROD_W > EXP_BITS) ? PROD_W : EXP_BITS;
   localparam int RED_W  = (RED_W0 > OPA_W) ? RED_W0 : OPA_W;
   localparam int CNT_W  = $clog2(RED_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RED_W - 1);

   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [RED_W-1:0]    x_ff, x_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] res_ff, res_in;

   logic [MOD_BITS-1:0] mul_x, mul_y;
   logic [PROD_W-1:0]   product;
   logic [RED_W-1:0]    red_src_val;
   logic [MOD_BITS:0]   trial, trial_sub, sum, sum_sub, diff;
   logic [MOD_BITS-1:0] rem_step, add_res, sub_res;
   logic                red_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff  <= MOD_BITS'(MOD_RESET);
         busy_ff <= 1'b0;
      end else begin
         mod_ff  <= mod_in;
         busy_ff <= busy_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      res_ff  <= res_in;
   end

   always_comb begin
      case (ctl.mul_sel)
         MUL_AB: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         MUL_ACC_BASE: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
         MUL_SQR: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
         default: begin
            mul_x = acc_ff;
            mul_y = a_ff;
         end
      endcase
   end

   assign product = PROD_W'(mul_x) * PROD_W'(mul_y);

   always_comb begin
      case (ctl.red_src)
         SRC_OPA: red_src_val = RED_W'(req_operand_a);
         SRC_OPB: red_src_val = RED_W'(exp_ff);
         SRC_MUL: red_src_val = RED_W'(product);
         default: red_src_val = '0;
      endcase
   end

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial     = {rem_ff, x_ff[RED_W-1]};
   assign trial_sub = trial - {1'b0, mod_ff};
   assign rem_step  = (trial >= {1'b0, mod_ff}) ? trial_sub[MOD_BITS-1:0]
                                                 : trial[MOD_BITS-1:0];
   assign red_done  = busy_ff && (cnt_ff == '0);

   assign sum     = {1'b0, a_ff} + {1'b0, b_ff};
   assign sum_sub = sum - {1'b0, mod_ff};
   assign add_res = (sum >= {1'b0, mod_ff}) ? sum_sub[MOD_BITS-1:0] : sum[MOD_BITS-1:0];
   assign diff    = {1'b0, a_ff} + {1'b0, mod_ff} - {1'b0, b_ff};
   assign sub_res = (a_ff >= b_ff) ? (a_ff - b_ff) : diff[MOD_BITS-1:0];

   always_comb begin
      mod_in  = mod_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      exp_in  = exp_ff;
      res_in  = res_ff;

      if (csr_we) begin
         mod_in = csr_modulus;
      end
      if (ctl.load) begin
         exp_in = req_operand_b;
      end

      if (ctl.red_start) begin
         x_in    = red_src_val;
         rem_in  = '0;
         cnt_in  = CNT_LAST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = {x_ff[RED_W-2:0], 1'b0};
         rem_in = rem_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end

      if (red_done) begin
         case (ctl.dst)
            DST_A:    a_in    = rem_step;
            DST_B:    b_in    = rem_step;
            DST_ACC:  acc_in  = rem_step;
            DST_BASE: base_in = rem_step;
            DST_RES:  res_in  = rem_step;
            default:  ;
         endcase
      end

      if (ctl.pow_init) begin
         base_in = ctl.base_from_b ? b_ff : a_ff;
         // The accumulator starts at one reduced by the modulus.
         acc_in  = sts.mod_lt2 ? '0 : MOD_BITS'(1);
         if (ctl.exp_from_mod) begin
            exp_in = EXP_BITS'(mod_ff - MOD_BITS'(2));
         end
      end
      if (ctl.exp_shift) begin
         exp_in = exp_ff >> 1;
      end

      case (ctl.res_op)
         RES_ADD:  res_in = add_res;
         RES_SUB:  res_in = sub_res;
         RES_ACC:  res_in = acc_ff;
         RES_ZERO: res_in = '0;
         default:  ;
      endcase
   end

   assign sts.red_busy = busy_ff;
   assign sts.red_done = red_done;
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_lsb  = exp_ff[0];
   assign sts.mod_zero = (mod_ff == '0);
   assign sts.mod_lt2  = (mod_ff < MOD_BITS'(2));

   assign rsp_result = RES_W'(res_ff);

`ifndef SYNTHESIS
   // A reduced result always lands below the modulus it was reduced by.
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      (red_done && (ctl.dst == DST_RES)) |=> (res_ff < $past(mod_ff)))
      else $error("reduced result not below the modulus");

   // The exponent is only shifted while bits remain.
   a_exp_shift_live: assert property (@(posedge clock) disable iff (reset)
      ctl.exp_shift |-> !sts.exp_zero)
      else $error("exponent shifted after it reached zero");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for modular_arithmetic_unit: directed and random words on the
// request channel, residues predicted in the bench and compared on the response channel.
// Depends on mau_pkg and the mau_req_if, mau_rsp_if and mau_csr_if interfaces.
`default_nettype none

module testbench;
   import mau_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MW = MOD_BITS_DEF;
   localparam int EW = EXP_BITS_DEF;

   localparam logic [CMD_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] OP_RSVD7 = 3'd7;

   localparam logic [OPA_W-1:0] OPA_ALL_ONES = '1;
   localparam logic [EW-1:0]    EXP_ALL_ONES = '1;
   localparam logic [MW-1:0]    MOD_MAX      = '1;
   localparam logic [MW-1:0]    MOD_DEFAULT  = MOD_RESET[MW-1:0];

   // Bound on the run: the slowest word for every word, plus the longest gaps, thrice.
   localparam longint CYCLE_LIMIT = 64'd50_000_000;

   logic clock;
   logic reset;

   mau_req_if #(.EXP_BITS(EW)) req_bus ();
   mau_rsp_if                  rsp_bus ();
   mau_csr_if #(.MOD_BITS(MW)) csr_bus ();

   modular_arithmetic_unit #(.MOD_BITS(MW), .EXP_BITS(EW)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [MW-1:0]    modulus_shadow;
   logic [RES_W-1:0] expected_residues[$];
   int               mismatch_count;
   int               hold_off_cycles;
   bit               idle_on;
   longint           cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   function automatic longint unsigned power_residue(input longint unsigned base,
                                                     input longint unsigned expo,
                                                     input longint unsigned m);
      longint unsigned acc;
      acc  = 1 % m;
      base = base % m;
      for (int i = 0; i < EW; i++) begin
         if (expo[0])
            acc = (acc * base) % m;
         base = (base * base) % m;
         expo = expo >> 1;
      end
      return acc;
   endfunction

   function automatic logic [RES_W-1:0] predict_residue(input logic [CMD_W-1:0] op,
                                                        input logic [OPA_W-1:0] a,
                                                        input logic [EW-1:0]    b);
      longint unsigned m, ar, br, r;
      m = modulus_shadow;
      r = 0;
      if (m != 0) begin
         ar = longint'(a) % m;
         br = longint'(b) % m;
         case (op)
            OP_ADD: r = (ar + br) % m;
            OP_SUB: r = (ar >= br) ? ar - br : ar + m - br;
            OP_MUL: r = (ar * br) % m;
            OP_POW: r = power_residue(ar, longint'(b), m);
            OP_INV: r = (m >= 2) ? power_residue(ar, m - 2, m) : 0;
            OP_DIV: r = (m >= 2) ? (ar * power_residue(br, m - 2, m)) % m : 0;
            default: r = 0;
         endcase
      end
      return r[RES_W-1:0];
   endfunction

   // ---------------------------------------------------------------- random picks

   function automatic int idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 96) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 80));
   endfunction

   function automatic logic [CMD_W-1:0] pick_opcode();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 19) return OP_ADD;
      if (r < 38) return OP_SUB;
      if (r < 57) return OP_MUL;
      if (r < 78) return OP_POW;
      if (r < 86) return OP_INV;
      if (r < 94) return OP_DIV;
      if (r < 97) return OP_RSVD6;
      return OP_RSVD7;
   endfunction

   function automatic logic [OPA_W-1:0] pick_operand_a();
      logic [OPA_W-1:0] v;
      case ($urandom_range(0, 19))
         0: v = '0;
         1: v = OPA_ALL_ONES;
         2: v = modulus_shadow - 1'b1;
         3: v = modulus_shadow;
         default: v = OPA_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [EW-1:0] pick_operand_b();
      bit [63:0]     wide;
      logic [MW-1:0] edge_val;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0: wide = '0;
         1: wide = 64'(EXP_ALL_ONES);
         2: begin
            edge_val = modulus_shadow - 1'b1;
            wide = 64'(edge_val);
         end
         3: wide = 64'(modulus_shadow);
         4: wide = 64'($urandom_range(0, 15));
         default: ;
      endcase
      return wide[EW-1:0];
   endfunction

   // Most exponents are short to keep the run length sane; a few use all bits.
   function automatic logic [EW-1:0] pick_exponent();
      bit [63:0]   wide;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 72)
         wide = 64'($urandom_range(0, 255));
      else if (r < 97)
         wide = 64'($urandom_range(0, 65535));
      else
         wide = {$urandom, $urandom};
      return wide[EW-1:0];
   endfunction

   // ---------------------------------------------------------------- channel drivers

   task automatic send_word(input logic [CMD_W-1:0] op, input logic [OPA_W-1:0] a,
                            input logic [EW-1:0] b);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= op;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_residues = {expected_residues, predict_residue(op, a, b)};
      gap = idle_on ? idle_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_residues.size() != 0)
         @(posedge clock);
   endtask

   // Only called with the unit idle, after wait_for_results.
   task automatic write_modulus(input logic [MW-1:0] value);
      csr_bus.valid   <= 1'b1;
      csr_bus.modulus <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid  <= 1'b0;
      modulus_shadow = value;
   endtask

   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (1 + idle_gap()) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      logic [RES_W-1:0] want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_residues.size() == 0) begin
            $error("unexpected result word: result %0d", rsp_bus.result);
            mismatch_count++;
         end else begin
            want = expected_residues.pop_front();
            if (rsp_bus.result !== want) begin
               $error("result mismatch: expected %0d, actual %0d", want, rsp_bus.result);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Runs at the modulus left by reset, which is therefore checked too.
   task automatic test_directed_ops();
      idle_on = 1'b0;
      send_word(OP_ADD, '0, '0);
      send_word(OP_ADD, OPA_ALL_ONES, EXP_ALL_ONES);
      send_word(OP_SUB, '0, 63'd1);
      send_word(OP_SUB, MOD_DEFAULT, 63'(MOD_DEFAULT - 1'b1));
      send_word(OP_MUL, OPA_ALL_ONES, EXP_ALL_ONES);
      send_word(OP_MUL, MOD_DEFAULT - 1'b1, 63'(MOD_DEFAULT - 1'b1));
      send_word(OP_POW, 30'd2, '0);
      send_word(OP_POW, 30'd3, 63'd1);
      send_word(OP_POW, OPA_ALL_ONES, EXP_ALL_ONES);
      send_word(OP_INV, '0, '0);
      send_word(OP_INV, 30'd1, '0);
      send_word(OP_INV, MOD_DEFAULT - 1'b1, '0);
      send_word(OP_DIV, 30'd7, '0);
      send_word(OP_DIV, 30'd10, 63'd3);
      send_word(OP_RSVD6, OPA_ALL_ONES, EXP_ALL_ONES);
      send_word(OP_RSVD7, 30'd5, 63'd9);
      wait_for_results();
   endtask

   // Moduli zero, one and two, where inverse and divide degenerate.
   task automatic test_degenerate_moduli();
      write_modulus('0);
      send_word(OP_ADD, 30'd5, 63'd6);
      send_word(OP_POW, 30'd5, '0);
      send_word(OP_INV, 30'd5, '0);
      send_word(OP_DIV, 30'd5, 63'd3);
      wait_for_results();
      write_modulus(30'd1);
      send_word(OP_MUL, OPA_ALL_ONES, EXP_ALL_ONES);
      send_word(OP_POW, 30'd7, '0);
      send_word(OP_INV, 30'd3, '0);
      send_word(OP_SUB, '0, 63'd1);
      wait_for_results();
      write_modulus(30'd2);
      send_word(OP_INV, '0, '0);
      send_word(OP_INV, 30'd3, '0);
      send_word(OP_DIV, 30'd5, 63'd3);
      send_word(OP_POW, 30'd3, '0);
      wait_for_results();
   endtask

   // The sink holds off long enough for the unit to fill and stall its request side.
   task automatic test_back_pressure();
      write_modulus(30'd1000000007);
      idle_on = 1'b0;
      hold_off_cycles = 4000;
      repeat (12)
         send_word($urandom_range(0, 1) ? OP_ADD : OP_MUL, pick_operand_a(), pick_operand_b());
      wait_for_results();
   endtask

   task automatic test_random_sweep();
      logic [MW-1:0]    moduli[8];
      logic [CMD_W-1:0] op;
      logic [OPA_W-1:0] a;
      logic [EW-1:0]    b;
      moduli[0] = 30'd3;
      moduli[1] = MOD_MAX;
      moduli[2] = 30'd1000000007;
      moduli[3] = 30'd7;
      moduli[4] = 30'd65537;
      moduli[5] = MW'($urandom_range(3, MOD_MAX));
      moduli[6] = MW'($urandom_range(3, MOD_MAX));
      moduli[7] = MOD_DEFAULT;
      foreach (moduli[p]) begin
         write_modulus(moduli[p]);
         for (int i = 0; i < 228; i++) begin
            if (i % 40 == 0)
               idle_on = ($urandom_range(0, 2) != 0);
            op = pick_opcode();
            a  = pick_operand_a();
            b  = (op == OP_POW) ? pick_exponent() : pick_operand_b();
            send_word(op, a, b);
         end
         wait_for_results();
      end
   endtask

   initial begin
      cycle_count     = 0;
      mismatch_count  = 0;
      hold_off_cycles = 0;
      idle_on         = 1'b0;
      modulus_shadow  = MOD_DEFAULT;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= OP_ADD;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.modulus   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_degenerate_moduli();
      test_back_pressure();
      test_random_sweep();

      wait_for_results();
      // Any stray word arriving now is flagged by the checker.
      repeat (400) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

>>> modular_arithmetic_unit.f
design/mau_pkg.sv
design/mau_req_if.sv
design/mau_rsp_if.sv
design/mau_csr_if.sv
design/mau_ctrl.sv
design/mau_dpath.sv
design/modular_arithmetic_unit.sv
dv/testbench.sv
